FILE: rtl/core/ggc_pkg.sv
// Package for the geometric grading coefficient block.
// Holds fixed-point constants, codes, state and command types shared by all modules.
// No dependencies.
`default_nettype none

package ggc_pkg;

    localparam int MAX_EDGES    = 1024;
    localparam int BISECT_LIMIT = 100;
    localparam int CNT_W        = 11;
    localparam int IT_W         = 8;
    localparam int DCNT_W       = 7;

    localparam logic [CNT_W-1:0]  MAX_EDGES_C    = CNT_W'(MAX_EDGES);
    localparam logic [IT_W-1:0]   BISECT_LIMIT_C = IT_W'(BISECT_LIMIT);
    localparam logic [DCNT_W-1:0] DIV_STEPS      = DCNT_W'(64);

    localparam logic [63:0] ONE_Q28    = 64'h0000_0000_1000_0000;
    localparam logic [63:0] DIRECT_NHI = 64'h0000_0000_0100_0000;
    localparam logic [30:0] LOW_RATIO  = 31'h0400_0000;
    localparam logic [30:0] HIGH_RATIO = 31'h4000_0000;
    localparam logic [31:0] ONE_Q30    = 32'h4000_0000;
    localparam logic [63:0] MAX64      = 64'hFFFF_FFFF_FFFF_FFFF;

    localparam logic [31:0] RATIO_RESET = 32'h1000_0000;

    localparam logic CMD_INIT = 1'b0;
    localparam logic CMD_NEXT = 1'b1;

    localparam logic [1:0] REG_RATIO      = 2'd0;
    localparam logic [1:0] REG_EDGE_COUNT = 2'd1;
    localparam logic [1:0] REG_DIRECT     = 2'd2;
    localparam logic [1:0] REG_FIRST_ARM  = 2'd3;

    typedef enum logic [2:0] {
        ST_OK       = 3'd0,
        ST_NO_ROOT  = 3'd1,
        ST_ZERO     = 3'd2,
        ST_PAST_END = 3'd3,
        ST_NOT_INIT = 3'd4,
        ST_OVERFLOW = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        DS_TARGET,
        DS_DIRECT,
        DS_REVERSE,
        DS_NEXT
    } div_src_t;

    typedef enum logic [1:0] {
        MID_LOW,
        MID_HIGH,
        MID_BISECT
    } mid_sel_t;

    typedef enum logic [1:0] {
        RIN_ZERO,
        RIN_CFG,
        RIN_MID
    } rin_sel_t;

    typedef enum logic [1:0] {
        PASS_LG1,
        PASS_LG2,
        PASS_MID
    } pass_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_NEXT,
        S_NEXT_MH,
        S_NEXT_ML,
        S_NEXT_DW,
        S_NEXT_ADD,
        S_NEXT_FIN,
        S_INIT,
        S_TGT_WAIT,
        S_POLY_ADD,
        S_POLY_MH,
        S_POLY_ML,
        S_POLY_END,
        S_BIS_CHK,
        S_BIS_LOOP,
        S_BIS_UPD,
        S_SUM_START,
        S_SUM_CHK,
        S_SUM_MH,
        S_SUM_ML,
        S_SUM_ADD,
        S_SUM_END,
        S_PN_MH,
        S_PN_ML,
        S_PN_DIV,
        S_INIT_DW,
        S_INIT_FIN,
        S_DONE
    } state_t;

    typedef struct packed {
        logic     accept;
        logic     init_clear;
        logic     ovf_clr;
        logic     st_wr;
        logic     st_okovf;
        status_t  st_code;
        logic     div_load;
        div_src_t div_src;
        logic     tgt_wr;
        logic     mul_hi;
        logic     mul_mid;
        logic     mul_term;
        logic     p_wr_mul;
        logic     term_wr_mul;
        logic     poly_start;
        logic     s_add;
        logic     mid_set;
        mid_sel_t mid_sel;
        logic     lg1_wr;
        logic     bis_init;
        logic     bis_upd;
        logic     rin_wr;
        rin_sel_t rin_sel;
        logic     sum_wr;
        logic     term_wr_div;
        logic     frac_add;
        logic     init_set;
        logic     out_load;
    } ggc_cmd_t;

    typedef struct packed {
        logic is_init;
        logic at_end;
        logic dir;
        logic fal_zero;
        logic div_done;
        logic j_done;
        logic no_root;
        logic bis_more;
        logic zero_ratio;
        logic ovf;
    } ggc_stat_t;

endpackage

`default_nettype wire

FILE: rtl/core/ggc_ctrl.sv
// Controller state machine for the geometric grading coefficient block.
// Sequences init, ratio solving, series build and next steps over the datapath.
// Depends on ggc_pkg.
`default_nettype none

module ggc_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic              command,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire ggc_pkg::ggc_stat_t stat,
    output ggc_pkg::ggc_cmd_t      cmd
);

    ggc_pkg::state_t state_reg, state_next;
    ggc_pkg::pass_t  pass_reg, pass_next;
    logic            out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ggc_pkg::S_IDLE;
            pass_reg      <= ggc_pkg::PASS_LG1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            pass_reg      <= pass_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_ready  = (state_reg == ggc_pkg::S_IDLE);
    assign out_valid = out_valid_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        pass_next  = pass_reg;
        unique case (state_reg)
            ggc_pkg::S_IDLE:
            begin
                if (in_valid)
                    state_next = (command == ggc_pkg::CMD_NEXT) ? ggc_pkg::S_NEXT
                                                                : ggc_pkg::S_INIT;
            end
            ggc_pkg::S_NEXT:
            begin
                priority if (!stat.is_init) state_next = ggc_pkg::S_DONE;
                else if (stat.at_end)       state_next = ggc_pkg::S_DONE;
                else if (stat.dir)          state_next = ggc_pkg::S_NEXT_MH;
                else                        state_next = ggc_pkg::S_NEXT_DW;
            end
            ggc_pkg::S_NEXT_MH:  state_next = ggc_pkg::S_NEXT_ML;
            ggc_pkg::S_NEXT_ML:  state_next = ggc_pkg::S_NEXT_ADD;
            ggc_pkg::S_NEXT_DW:
            begin
                if (stat.div_done) state_next = ggc_pkg::S_NEXT_ADD;
            end
            ggc_pkg::S_NEXT_ADD: state_next = ggc_pkg::S_NEXT_FIN;
            ggc_pkg::S_NEXT_FIN: state_next = ggc_pkg::S_DONE;
            ggc_pkg::S_INIT:
            begin
                state_next = stat.fal_zero ? ggc_pkg::S_SUM_START : ggc_pkg::S_TGT_WAIT;
            end
            ggc_pkg::S_TGT_WAIT:
            begin
                if (stat.div_done)
                begin
                    state_next = ggc_pkg::S_POLY_ADD;
                    pass_next  = ggc_pkg::PASS_LG1;
                end
            end
            ggc_pkg::S_POLY_ADD:
            begin
                state_next = stat.j_done ? ggc_pkg::S_POLY_END : ggc_pkg::S_POLY_MH;
            end
            ggc_pkg::S_POLY_MH:  state_next = ggc_pkg::S_POLY_ML;
            ggc_pkg::S_POLY_ML:  state_next = ggc_pkg::S_POLY_ADD;
            ggc_pkg::S_POLY_END:
            begin
                unique case (pass_reg)
                    ggc_pkg::PASS_LG1:
                    begin
                        state_next = ggc_pkg::S_POLY_ADD;
                        pass_next  = ggc_pkg::PASS_LG2;
                    end
                    ggc_pkg::PASS_LG2: state_next = ggc_pkg::S_BIS_CHK;
                    default:           state_next = ggc_pkg::S_BIS_UPD;
                endcase
            end
            ggc_pkg::S_BIS_CHK:
            begin
                state_next = stat.no_root ? ggc_pkg::S_DONE : ggc_pkg::S_BIS_LOOP;
            end
            ggc_pkg::S_BIS_LOOP:
            begin
                if (stat.bis_more)
                begin
                    state_next = ggc_pkg::S_POLY_ADD;
                    pass_next  = ggc_pkg::PASS_MID;
                end
                else
                    state_next = ggc_pkg::S_SUM_START;
            end
            ggc_pkg::S_BIS_UPD:   state_next = ggc_pkg::S_BIS_LOOP;
            ggc_pkg::S_SUM_START: state_next = ggc_pkg::S_SUM_CHK;
            ggc_pkg::S_SUM_CHK:
            begin
                state_next = stat.j_done ? ggc_pkg::S_SUM_END : ggc_pkg::S_SUM_MH;
            end
            ggc_pkg::S_SUM_MH:  state_next = ggc_pkg::S_SUM_ML;
            ggc_pkg::S_SUM_ML:  state_next = ggc_pkg::S_SUM_ADD;
            ggc_pkg::S_SUM_ADD: state_next = ggc_pkg::S_SUM_CHK;
            ggc_pkg::S_SUM_END:
            begin
                priority if (stat.zero_ratio) state_next = ggc_pkg::S_DONE;
                else if (stat.ovf)            state_next = ggc_pkg::S_DONE;
                else if (stat.dir)            state_next = ggc_pkg::S_INIT_DW;
                else                          state_next = ggc_pkg::S_PN_MH;
            end
            ggc_pkg::S_PN_MH:  state_next = ggc_pkg::S_PN_ML;
            ggc_pkg::S_PN_ML:  state_next = ggc_pkg::S_PN_DIV;
            ggc_pkg::S_PN_DIV: state_next = ggc_pkg::S_INIT_DW;
            ggc_pkg::S_INIT_DW:
            begin
                if (stat.div_done) state_next = ggc_pkg::S_INIT_FIN;
            end
            ggc_pkg::S_INIT_FIN: state_next = ggc_pkg::S_DONE;
            ggc_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready) state_next = ggc_pkg::S_IDLE;
            end
            default: state_next = ggc_pkg::S_IDLE;
        endcase
    end

    // outputs
    always_comb
    begin
        cmd            = '0;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            ggc_pkg::S_IDLE:
            begin
                cmd.accept = in_valid;
            end
            ggc_pkg::S_NEXT:
            begin
                cmd.ovf_clr = 1'b1;
                priority if (!stat.is_init)
                begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ggc_pkg::ST_NOT_INIT;
                end
                else if (stat.at_end)
                begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ggc_pkg::ST_PAST_END;
                end
                else if (!stat.dir)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = ggc_pkg::DS_NEXT;
                end
            end
            ggc_pkg::S_NEXT_MH:
            begin
                cmd.mul_hi   = 1'b1;
                cmd.mul_term = 1'b1;
            end
            ggc_pkg::S_NEXT_ML:
            begin
                cmd.mul_term    = 1'b1;
                cmd.term_wr_mul = 1'b1;
            end
            ggc_pkg::S_NEXT_DW:
            begin
                cmd.term_wr_div = stat.div_done;
            end
            ggc_pkg::S_NEXT_ADD:
            begin
                cmd.frac_add = 1'b1;
            end
            ggc_pkg::S_NEXT_FIN:
            begin
                cmd.st_wr    = 1'b1;
                cmd.st_okovf = 1'b1;
            end
            ggc_pkg::S_INIT:
            begin
                cmd.init_clear = 1'b1;
                cmd.ovf_clr    = 1'b1;
                if (stat.fal_zero)
                begin
                    cmd.rin_wr  = 1'b1;
                    cmd.rin_sel = ggc_pkg::RIN_CFG;
                end
                else
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = ggc_pkg::DS_TARGET;
                end
            end
            ggc_pkg::S_TGT_WAIT:
            begin
                if (stat.div_done)
                begin
                    cmd.tgt_wr     = 1'b1;
                    cmd.mid_set    = 1'b1;
                    cmd.mid_sel    = ggc_pkg::MID_LOW;
                    cmd.poly_start = 1'b1;
                end
            end
            ggc_pkg::S_POLY_ADD:
            begin
                cmd.s_add = !stat.j_done;
            end
            ggc_pkg::S_POLY_MH:
            begin
                cmd.mul_hi  = 1'b1;
                cmd.mul_mid = 1'b1;
            end
            ggc_pkg::S_POLY_ML:
            begin
                cmd.mul_mid  = 1'b1;
                cmd.p_wr_mul = 1'b1;
            end
            ggc_pkg::S_POLY_END:
            begin
                if (pass_reg == ggc_pkg::PASS_LG1)
                begin
                    cmd.lg1_wr     = 1'b1;
                    cmd.mid_set    = 1'b1;
                    cmd.mid_sel    = ggc_pkg::MID_HIGH;
                    cmd.poly_start = 1'b1;
                end
            end
            ggc_pkg::S_BIS_CHK:
            begin
                if (stat.no_root)
                begin
                    cmd.rin_wr  = 1'b1;
                    cmd.rin_sel = ggc_pkg::RIN_ZERO;
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ggc_pkg::ST_NO_ROOT;
                end
                else
                    cmd.bis_init = 1'b1;
            end
            ggc_pkg::S_BIS_LOOP:
            begin
                if (stat.bis_more)
                begin
                    cmd.mid_set    = 1'b1;
                    cmd.mid_sel    = ggc_pkg::MID_BISECT;
                    cmd.poly_start = 1'b1;
                end
                else
                begin
                    cmd.rin_wr  = 1'b1;
                    cmd.rin_sel = ggc_pkg::RIN_MID;
                end
            end
            ggc_pkg::S_BIS_UPD:
            begin
                cmd.bis_upd = 1'b1;
            end
            ggc_pkg::S_SUM_START:
            begin
                cmd.poly_start = 1'b1;
            end
            ggc_pkg::S_SUM_MH:
            begin
                cmd.mul_hi = 1'b1;
            end
            ggc_pkg::S_SUM_ML:
            begin
                cmd.p_wr_mul = 1'b1;
            end
            ggc_pkg::S_SUM_ADD:
            begin
                cmd.s_add = 1'b1;
            end
            ggc_pkg::S_SUM_END:
            begin
                cmd.sum_wr = 1'b1;
                priority if (stat.zero_ratio)
                begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ggc_pkg::ST_ZERO;
                end
                else if (stat.ovf)
                begin
                    cmd.st_wr   = 1'b1;
                    cmd.st_code = ggc_pkg::ST_OVERFLOW;
                end
                else if (stat.dir)
                begin
                    cmd.div_load = 1'b1;
                    cmd.div_src  = ggc_pkg::DS_DIRECT;
                end
            end
            ggc_pkg::S_PN_MH:
            begin
                cmd.mul_hi = 1'b1;
            end
            ggc_pkg::S_PN_ML:
            begin
                cmd.p_wr_mul = 1'b1;
            end
            ggc_pkg::S_PN_DIV:
            begin
                cmd.div_load = 1'b1;
                cmd.div_src  = ggc_pkg::DS_REVERSE;
            end
            ggc_pkg::S_INIT_DW:
            begin
                cmd.term_wr_div = stat.div_done;
            end
            ggc_pkg::S_INIT_FIN:
            begin
                cmd.st_wr    = 1'b1;
                cmd.st_okovf = 1'b1;
                cmd.init_set = !stat.ovf;
            end
            ggc_pkg::S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    cmd.out_load   = 1'b1;
                    out_valid_next = 1'b1;
                end
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

`default_nettype wire

FILE: rtl/core/ggc_dp.sv
// Datapath for the geometric grading coefficient block: state, shared
// 32x32 multiplier, bit-serial divider, bisection registers, output word.
// Depends on ggc_pkg.
`default_nettype none

module ggc_dp (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire ggc_pkg::ggc_cmd_t  cmd,
    output ggc_pkg::ggc_stat_t      stat,
    input  wire logic [31:0]        edge_length,
    input  wire logic [31:0]        ratio_cfg,
    input  wire logic [10:0]        edge_count_cfg,
    input  wire logic               direct_cfg,
    input  wire logic [31:0]        first_arm_cfg,
    output logic [30:0]             fraction,
    output logic [10:0]             node_index,
    output logic                    last,
    output logic [31:0]             ratio_used,
    output logic [2:0]              status
);

    // architectural state
    logic [31:0] rin_reg;
    logic [63:0] sum_reg;
    logic [63:0] term_reg;
    logic [63:0] frac_reg;
    logic [10:0] cnt_reg;
    logic        init_reg;

    // scratch
    logic [31:0] len_reg;
    logic [63:0] p_reg;
    logic [63:0] s_reg;
    logic [10:0] j_reg;
    logic        ovf_reg;
    logic [63:0] tgt_reg;
    logic [63:0] lg1_reg;
    logic        up_reg;
    logic [30:0] r1_reg;
    logic [30:0] r2_reg;
    logic [30:0] mid_reg;
    logic [ggc_pkg::IT_W-1:0] it_reg;
    ggc_pkg::status_t st_reg;
    logic [63:0] hi_reg;

    // divider
    logic [63:0] rem_reg;
    logic [63:0] dq_reg;
    logic [63:0] dd_reg;
    logic [ggc_pkg::DCNT_W-1:0] dcnt_reg;
    logic        dovf_reg;

    // output word
    logic [30:0] fraction_reg;
    logic [10:0] node_reg;
    logic        last_reg;
    logic [31:0] ratio_reg;
    logic [2:0]  status_reg;

    logic [10:0] n_eff;
    always_comb
    begin
        priority if (edge_count_cfg == 11'd0)           n_eff = 11'd1;
        else if (edge_count_cfg > ggc_pkg::MAX_EDGES_C) n_eff = ggc_pkg::MAX_EDGES_C;
        else                                            n_eff = edge_count_cfg;
    end

    // multiply by ratio, >> 28, saturating
    logic [63:0] mul_src;
    logic [31:0] mul_r;
    logic [63:0] lo_prod;
    logic [64:0] mul_sum;
    logic        mul_ovf;
    logic [63:0] mul_res;
    assign mul_src = cmd.mul_term ? term_reg : p_reg;
    assign mul_r   = cmd.mul_mid ? {1'b0, mid_reg} : rin_reg;
    assign lo_prod = mul_src[31:0] * mul_r;
    assign mul_sum = {1'b0, hi_reg[59:0], 4'b0000} + {29'd0, lo_prod[63:28]};
    assign mul_ovf = (hi_reg[63:60] != 4'd0) || mul_sum[64];
    assign mul_res = mul_ovf ? ggc_pkg::MAX64 : mul_sum[63:0];

    // saturating adds
    logic [64:0] s_sum;
    logic [64:0] f_sum;
    assign s_sum = {1'b0, s_reg} + {1'b0, p_reg};
    assign f_sum = {1'b0, frac_reg} + {1'b0, term_reg};

    // divider operands
    logic [63:0] d_nhi;
    logic [63:0] d_nlo;
    logic [63:0] d_den;
    always_comb
    begin
        unique case (cmd.div_src)
            ggc_pkg::DS_TARGET:
            begin
                d_nhi = 64'd0;
                d_nlo = {4'd0, len_reg, 28'd0};
                d_den = {32'd0, first_arm_cfg};
            end
            ggc_pkg::DS_DIRECT:
            begin
                d_nhi = ggc_pkg::DIRECT_NHI;
                d_nlo = 64'd0;
                d_den = s_reg;
            end
            ggc_pkg::DS_REVERSE:
            begin
                d_nhi = {4'd0, p_reg[63:4]};
                d_nlo = {p_reg[3:0], 60'd0};
                d_den = s_reg;
            end
            default:
            begin
                d_nhi = {36'd0, term_reg[63:36]};
                d_nlo = {term_reg[35:0], 28'd0};
                d_den = {32'd0, rin_reg};
            end
        endcase
    end

    logic [63:0] rem_sh;
    logic        d_geq;
    logic [63:0] quo;
    assign rem_sh = {rem_reg[62:0], dq_reg[63]};
    assign d_geq  = rem_reg[63] || (rem_sh >= dd_reg);
    assign quo    = dovf_reg ? ggc_pkg::MAX64 : dq_reg;

    logic [30:0] r_mid;
    logic [31:0] r_span;
    assign r_mid  = 31'(({1'b0, r1_reg} + {1'b0, r2_reg}) >> 1);
    assign r_span = {1'b0, r2_reg} - {1'b0, r1_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rin_reg  <= 32'd0;
            sum_reg  <= 64'd0;
            term_reg <= 64'd0;
            frac_reg <= 64'd0;
            cnt_reg  <= 11'd0;
            init_reg <= 1'b0;
            rem_reg  <= 64'd0;
            dq_reg   <= 64'd0;
            dd_reg   <= 64'd0;
            dcnt_reg <= '0;
            dovf_reg <= 1'b0;
            ovf_reg  <= 1'b0;
        end
        else
        begin
            if (cmd.init_clear)
            begin
                init_reg <= 1'b0;
                cnt_reg  <= 11'd0;
                frac_reg <= 64'd0;
            end
            if (cmd.init_set)
                init_reg <= 1'b1;
            if (cmd.ovf_clr || cmd.poly_start)
                ovf_reg <= 1'b0;
            if (cmd.p_wr_mul || cmd.term_wr_mul)
                ovf_reg <= ovf_reg | mul_ovf;
            if (cmd.s_add)
                ovf_reg <= ovf_reg | s_sum[64];
            if (cmd.frac_add)
                ovf_reg <= ovf_reg | f_sum[64];
            if (cmd.term_wr_div)
                ovf_reg <= ovf_reg | dovf_reg;
            if (cmd.term_wr_mul)
                term_reg <= mul_res;
            if (cmd.term_wr_div)
                term_reg <= quo;
            if (cmd.frac_add)
            begin
                frac_reg <= f_sum[64] ? ggc_pkg::MAX64 : f_sum[63:0];
                cnt_reg  <= cnt_reg + 11'd1;
            end
            if (cmd.sum_wr)
                sum_reg <= s_reg;
            if (cmd.rin_wr)
            begin
                unique case (cmd.rin_sel)
                    ggc_pkg::RIN_ZERO: rin_reg <= 32'd0;
                    ggc_pkg::RIN_CFG:  rin_reg <= ratio_cfg;
                    default:           rin_reg <= {1'b0, mid_reg};
                endcase
            end
            if (cmd.div_load)
            begin
                rem_reg  <= d_nhi;
                dq_reg   <= d_nlo;
                dd_reg   <= d_den;
                dovf_reg <= (d_nhi >= d_den);
                dcnt_reg <= (d_nhi >= d_den) ? '0 : ggc_pkg::DIV_STEPS;
            end
            else if (dcnt_reg != '0)
            begin
                rem_reg  <= d_geq ? (rem_sh - dd_reg) : rem_sh;
                dq_reg   <= {dq_reg[62:0], d_geq};
                dcnt_reg <= dcnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
            len_reg <= edge_length;
        if (cmd.mul_hi)
            hi_reg <= mul_src[63:32] * mul_r;
        if (cmd.poly_start)
        begin
            p_reg <= ggc_pkg::ONE_Q28;
            s_reg <= 64'd0;
            j_reg <= 11'd0;
        end
        if (cmd.p_wr_mul)
            p_reg <= mul_res;
        if (cmd.s_add)
        begin
            s_reg <= s_sum[64] ? ggc_pkg::MAX64 : s_sum[63:0];
            j_reg <= j_reg + 11'd1;
        end
        if (cmd.tgt_wr)
            tgt_reg <= quo;
        if (cmd.lg1_wr)
            lg1_reg <= s_reg;
        if (cmd.mid_set)
        begin
            unique case (cmd.mid_sel)
                ggc_pkg::MID_LOW:  mid_reg <= ggc_pkg::LOW_RATIO;
                ggc_pkg::MID_HIGH: mid_reg <= ggc_pkg::HIGH_RATIO;
                default:           mid_reg <= r_mid;
            endcase
            if (cmd.mid_sel == ggc_pkg::MID_BISECT)
                it_reg <= it_reg + 1'b1;
        end
        if (cmd.bis_init)
        begin
            r1_reg <= ggc_pkg::LOW_RATIO;
            r2_reg <= ggc_pkg::HIGH_RATIO;
            it_reg <= '0;
            up_reg <= (lg1_reg < s_reg);
        end
        if (cmd.bis_upd)
        begin
            if (up_reg ? (s_reg > tgt_reg) : (s_reg < tgt_reg))
                r2_reg <= mid_reg;
            else
                r1_reg <= mid_reg;
        end
        if (cmd.st_wr)
            st_reg <= cmd.st_okovf ? (ovf_reg ? ggc_pkg::ST_OVERFLOW : ggc_pkg::ST_OK)
                                   : cmd.st_code;
    end

    // round Q4.60 to Q2.30, clamp at one
    logic [61:0] rnd_sum;
    logic [31:0] rnd_q;
    logic [30:0] frac_out;
    assign rnd_sum = {1'b0, frac_reg[60:0]} + 62'h0000_0000_2000_0000;
    assign rnd_q   = rnd_sum[61:30];
    always_comb
    begin
        priority if (st_reg == ggc_pkg::ST_NOT_INIT) frac_out = 31'd0;
        else if (frac_reg[63:61] != 3'd0)            frac_out = ggc_pkg::ONE_Q30[30:0];
        else if (rnd_q > ggc_pkg::ONE_Q30)           frac_out = ggc_pkg::ONE_Q30[30:0];
        else                                         frac_out = rnd_q[30:0];
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            fraction_reg <= frac_out;
            node_reg     <= cnt_reg;
            last_reg     <= (st_reg != ggc_pkg::ST_NOT_INIT) && (cnt_reg == n_eff);
            ratio_reg    <= rin_reg;
            status_reg   <= st_reg;
        end
    end

    assign fraction   = fraction_reg;
    assign node_index = node_reg;
    assign last       = last_reg;
    assign ratio_used = ratio_reg;
    assign status     = status_reg;

    assign stat.is_init    = init_reg;
    assign stat.at_end     = (cnt_reg >= n_eff);
    assign stat.dir        = direct_cfg;
    assign stat.fal_zero   = (first_arm_cfg == 32'd0);
    assign stat.div_done   = (dcnt_reg == '0);
    assign stat.j_done     = (j_reg == n_eff);
    assign stat.no_root    = ((lg1_reg < tgt_reg) && (s_reg < tgt_reg))
                          || ((lg1_reg > tgt_reg) && (s_reg > tgt_reg));
    assign stat.bis_more   = (r_span > 32'd1) && (it_reg < ggc_pkg::BISECT_LIMIT_C);
    assign stat.zero_ratio = (rin_reg == 32'd0) || (s_reg == 64'd0);
    assign stat.ovf        = ovf_reg;

endmodule

`default_nettype wire

FILE: rtl/core/geometric_grading_coefficients.sv
// Top level of the geometric grading coefficient block: configuration
// registers, controller and datapath. Depends on ggc_pkg, ggc_ctrl, ggc_dp.
//
// Channels: config writes (cfg_valid/cfg_ready, cfg_index, cfg_data) are
// always taken; input words (command, edge_length) on in_valid/in_ready;
// one result word per input on out_valid/out_ready.
// A next word uses the shared 32x32 multiply (high half, then low half)
// in direct mode and the 64-step bit-serial divider in reverse mode.
// An init word with a configured ratio runs one series evaluation and a
// final divide; with a first arm length it adds a 64-step target divide
// and one series evaluation per bisection step, for the two interval
// ends and up to 30 midpoints. One word is worked at a time.
// Reset clears the state and loads the register reset values; no result
// is pending. A finished result waits in the output register while the
// receiver stalls; the next input word is accepted meanwhile, and its
// result is held back until the output register frees.
`default_nettype none

module geometric_grading_coefficients (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [31:0] cfg_data,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic        command,
    input  wire logic [31:0] edge_length,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [30:0]      fraction,
    output logic [10:0]      node_index,
    output logic             last,
    output logic [31:0]      ratio_used,
    output logic [2:0]       status
);

    logic [31:0] ratio_reg;
    logic [10:0] edge_count_reg;
    logic        direct_reg;
    logic [31:0] first_arm_reg;

    ggc_pkg::ggc_cmd_t  cmd;
    ggc_pkg::ggc_stat_t stat;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ratio_reg      <= ggc_pkg::RATIO_RESET;
            edge_count_reg <= 11'd1;
            direct_reg     <= 1'b1;
            first_arm_reg  <= 32'd0;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                ggc_pkg::REG_RATIO:      ratio_reg      <= cfg_data;
                ggc_pkg::REG_EDGE_COUNT: edge_count_reg <= cfg_data[10:0];
                ggc_pkg::REG_DIRECT:     direct_reg     <= cfg_data[0];
                default:                 first_arm_reg  <= cfg_data;
            endcase
        end
    end

    ggc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .command   (command),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ggc_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .edge_length    (edge_length),
        .ratio_cfg      (ratio_reg),
        .edge_count_cfg (edge_count_reg),
        .direct_cfg     (direct_reg),
        .first_arm_cfg  (first_arm_reg),
        .fraction       (fraction),
        .node_index     (node_index),
        .last           (last),
        .ratio_used     (ratio_used),
        .status         (status)
    );

endmodule

`default_nettype wire

FILE: bench/ggc_checker.sv
`timescale 1ns / 100ps
// Scoreboard for the geometric grading coefficient block: tracks config
// writes, predicts one result word per accepted input word, compares.
// Depends on ggc_pkg.
module ggc_checker
    import ggc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [31:0] cfg_data,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic        command,
    input  logic [31:0] edge_length,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [30:0] fraction,
    input  logic [10:0] node_index,
    input  logic        last,
    input  logic [31:0] ratio_used,
    input  logic [2:0]  status,
    output int          fails,
    output int          pending,
    output int          results_seen
);

    typedef struct packed {
        logic [30:0] frac;
        logic [10:0] node;
        logic        last;
        logic [31:0] ratio;
        status_t     st;
    } grade_word_t;

    grade_word_t expected_q[$];

    bit [31:0] cfg_ratio;
    bit [10:0] cfg_n;
    bit        cfg_dir;
    bit [31:0] cfg_fal;

    bit [31:0] rin;
    bit [63:0] ssum;
    bit [63:0] term;
    bit [63:0] rfrac;
    bit [10:0] ncount;
    bit        inited;
    bit        sat_hit;

    initial fails = 0;

    task automatic report(input string what, input longint got, input longint want);
        $display("%0t mismatch %s: got %0h want %0h", $realtime, what, got, want);
        fails++;
    endtask

    function automatic bit [10:0] edge_eff();
        if (cfg_n == 0)
            return 11'd1;
        if (cfg_n > MAX_EDGES_C)
            return MAX_EDGES_C;
        return cfg_n;
    endfunction

    function automatic bit [63:0] add_sat(bit [63:0] a, bit [63:0] b);
        bit [63:0] s;
        s = a + b;
        if (s < a)
        begin
            sat_hit = 1'b1;
            return MAX64;
        end
        return s;
    endfunction

    function automatic bit [63:0] mul_q28(bit [63:0] a, bit [31:0] r);
        bit [63:0] hi, lo, top, res;
        hi = (a >> 32) * {32'b0, r};
        lo = {32'b0, a[31:0]} * {32'b0, r};
        if (hi >= (64'd1 << 60))
        begin
            sat_hit = 1'b1;
            return MAX64;
        end
        top = hi << 4;
        res = top + (lo >> 28);
        if (res < top)
        begin
            sat_hit = 1'b1;
            return MAX64;
        end
        return res;
    endfunction

    function automatic bit [63:0] div_q28(bit [63:0] a, bit [31:0] r);
        bit [63:0] q1, rem;
        q1 = a / {32'b0, r};
        rem = a % {32'b0, r};
        if (q1 >= (64'd1 << 36))
        begin
            sat_hit = 1'b1;
            return MAX64;
        end
        return (q1 << 28) + ((rem << 28) / {32'b0, r});
    endfunction

    function automatic bit [63:0] div_wide(bit [63:0] nhi, bit [63:0] nlo, bit [63:0] d);
        bit [63:0] rem, q;
        bit        top;
        if (nhi >= d)
        begin
            sat_hit = 1'b1;
            return MAX64;
        end
        rem = nhi;
        q = 0;
        for (int i = 0; i < 64; i++)
        begin
            top = rem[63];
            rem = {rem[62:0], nlo[63]};
            nlo = nlo << 1;
            q = q << 1;
            if (top || rem >= d)
            begin
                rem = rem - d;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic bit [63:0] series_at(bit [31:0] r, bit [10:0] n);
        bit [63:0] p, s;
        bit        keep;
        keep = sat_hit;
        p = ONE_Q28;
        s = 0;
        for (int j = 0; j < n; j++)
        begin
            s = add_sat(s, p);
            p = mul_q28(p, r);
        end
        sat_hit = keep;
        return s;
    endfunction

    function automatic bit [63:0] round_frac(bit [63:0] rf);
        bit [63:0] f;
        if (rf >= (64'd1 << 61))
            return {32'b0, ONE_Q30};
        f = (rf + (64'd1 << 29)) >> 30;
        return (f > {32'b0, ONE_Q30}) ? {32'b0, ONE_Q30} : f;
    endfunction

    function automatic status_t grade_init(bit [63:0] len);
        bit [10:0] n;
        bit [31:0] r;
        bit [63:0] p, s, pn1, tm, lg, r1, r2, mid, lg1, lg2, v;
        bit        up;
        int        it;
        n = edge_eff();
        r = cfg_ratio;
        p = ONE_Q28;
        s = 0;
        inited = 1'b0;
        ncount = 0;
        rfrac = 0;
        if (cfg_fal != 0)
        begin
            lg = (len << 28) / {32'b0, cfg_fal};
            r1 = {33'b0, LOW_RATIO};
            r2 = {33'b0, HIGH_RATIO};
            mid = 0;
            lg1 = series_at(r1[31:0], n);
            lg2 = series_at(r2[31:0], n);
            up = lg1 < lg2;
            it = 0;
            if ((lg1 < lg && lg2 < lg) || (lg1 > lg && lg2 > lg))
            begin
                rin = 0;
                return ST_NO_ROOT;
            end
            while (r2 - r1 > 1 && it < BISECT_LIMIT)
            begin
                it++;
                mid = (r1 + r2) >> 1;
                v = series_at(mid[31:0], n);
                if (up ? (v > lg) : (v < lg))
                    r2 = mid;
                else
                    r1 = mid;
            end
            r = mid[31:0];
        end
        rin = r;
        sat_hit = 1'b0;
        for (int j = 1; j <= n; j++)
        begin
            p = mul_q28(p, r);
            s = add_sat(s, p);
        end
        ssum = s;
        if (r == 0 || s == 0)
            return ST_ZERO;
        if (sat_hit)
            return ST_OVERFLOW;
        if (cfg_dir)
            tm = div_wide(DIRECT_NHI, 64'd0, s);
        else
        begin
            pn1 = mul_q28(p, r);
            tm = div_wide(pn1 >> 4, pn1 << 60, s);
        end
        term = tm;
        if (sat_hit)
            return ST_OVERFLOW;
        inited = 1'b1;
        return ST_OK;
    endfunction

    function automatic grade_word_t grade_step(logic cmd, bit [63:0] len);
        grade_word_t w;
        bit [10:0]   n;
        bit [63:0]   frac;
        status_t     st;
        n = edge_eff();
        frac = 0;
        if (cmd == CMD_INIT)
            st = grade_init(len);
        else if (!inited)
            st = ST_NOT_INIT;
        else if (ncount >= n)
        begin
            st = ST_PAST_END;
            frac = round_frac(rfrac);
        end
        else
        begin
            sat_hit = 1'b0;
            term = cfg_dir ? mul_q28(term, rin) : div_q28(term, rin);
            rfrac = add_sat(rfrac, term);
            ncount++;
            frac = round_frac(rfrac);
            st = sat_hit ? ST_OVERFLOW : ST_OK;
        end
        w.frac = frac[30:0];
        w.node = ncount;
        w.last = (st != ST_NOT_INIT) && (ncount == n);
        w.ratio = rin;
        w.st = st;
        return w;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        grade_word_t want;
        int          delta;
        if (!rst_n)
        begin
            cfg_ratio = RATIO_RESET;
            cfg_n = 11'd1;
            cfg_dir = 1'b1;
            cfg_fal = 32'd0;
            rin = 0;
            ssum = 0;
            term = 0;
            rfrac = 0;
            ncount = 0;
            inited = 1'b0;
            pending <= 0;
            results_seen <= 0;
            expected_q.delete();
        end
        else
        begin
            delta = 0;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_RATIO:      cfg_ratio = cfg_data;
                    REG_EDGE_COUNT: cfg_n = cfg_data[10:0];
                    REG_DIRECT:     cfg_dir = cfg_data[0];
                    REG_FIRST_ARM:  cfg_fal = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && in_ready)
            begin
                expected_q.push_back(grade_step(command, {32'b0, edge_length}));
                delta++;
            end
            if (out_valid && out_ready)
            begin
                results_seen <= results_seen + 1;
                if (expected_q.size() == 0)
                    report("unexpected word", {33'b0, fraction}, 0);
                else
                begin
                    want = expected_q.pop_front();
                    delta--;
                    if (fraction !== want.frac)
                        report("fraction", fraction, want.frac);
                    if (node_index !== want.node)
                        report("node_index", node_index, want.node);
                    if (last !== want.last)
                        report("last", last, want.last);
                    if (ratio_used !== want.ratio)
                        report("ratio_used", ratio_used, want.ratio);
                    if (status !== want.st)
                        report("status", status, want.st);
                end
            end
            pending <= pending + delta;
        end
    end

endmodule

FILE: bench/tb_top.sv
`timescale 1ns / 100ps
// Stimulus and verdict for the geometric grading coefficient block.
// Depends on ggc_pkg, geometric_grading_coefficients and ggc_checker.
module tb_top;
    import ggc_pkg::*;

    logic        clk;
    logic        rst_n;
    logic        cfg_valid;
    logic        cfg_ready;
    logic [1:0]  cfg_index;
    logic [31:0] cfg_data;
    logic        in_valid;
    logic        in_ready;
    logic        command;
    logic [31:0] edge_length;
    logic        out_valid;
    logic        out_ready;
    logic [30:0] fraction;
    logic [10:0] node_index;
    logic        last;
    logic [31:0] ratio_used;
    logic [2:0]  status;
    int          fails;
    int          pending;
    int          results_seen;

    int          burst_left;
    int          n_set;
    bit [63:0]   fal_set;

    geometric_grading_coefficients DUT (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .edge_length(edge_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .fraction(fraction), .node_index(node_index), .last(last),
        .ratio_used(ratio_used), .status(status)
    );

    ggc_checker u_checker (
        .clk(clk), .rst_n(rst_n),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready),
        .command(command), .edge_length(edge_length),
        .out_valid(out_valid), .out_ready(out_ready),
        .fraction(fraction), .node_index(node_index), .last(last),
        .ratio_used(ratio_used), .status(status),
        .fails(fails), .pending(pending), .results_seen(results_seen)
    );

    initial clk = 1'b0;
    always #4 clk = ~clk;

    initial
    begin
        #500_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    // receiver: stall pattern of its own, one long hold-off
    initial
    begin
        int mode;
        int mode_left;
        int hold_left;
        bit held;
        out_ready <= 1'b0;
        mode = 0;
        mode_left = 0;
        hold_left = 0;
        held = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!held && results_seen >= 300)
            begin
                held = 1'b1;
                hold_left = 600;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(10, 80);
                end
                mode_left--;
                case (mode)
                    0, 1:    out_ready <= 1'b1;
                    2:       out_ready <= $urandom_range(0, 1);
                    default: out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    task automatic send_word(input logic cmd, input logic [31:0] len);
        in_valid <= 1'b1;
        command <= cmd;
        edge_length <= len;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        if (burst_left == 0)
        begin
            in_valid <= 1'b0;
            burst_left = $urandom_range(1, 40);
            repeat ($urandom_range(1, 5))
                @(posedge clk);
        end
        else
            burst_left--;
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
    endtask

    task automatic set_config(input bit [31:0] r, input bit [10:0] n, input bit d,
                              input bit [31:0] fal);
        logic [31:0] vals [4];
        logic [1:0]  idx [4];
        wait_idle();
        vals = '{r, {21'b0, n}, {31'b0, d}, fal};
        idx = '{REG_RATIO, REG_EDGE_COUNT, REG_DIRECT, REG_FIRST_ARM};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 4; i++)
        begin
            cfg_index <= idx[i];
            cfg_data <= vals[i];
            @(posedge clk);
            while (!cfg_ready)
                @(posedge clk);
        end
        cfg_valid <= 1'b0;
        n_set = (n == 0) ? 1 : ((n > MAX_EDGES) ? MAX_EDGES : n);
        fal_set = fal;
    endtask

    function automatic logic [31:0] pick_length();
        bit [63:0] v;
        if (fal_set != 0 && $urandom_range(0, 9) != 0)
        begin
            v = fal_set * 64'(n_set * $urandom_range(48, 640)) / 256;
            return (v > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : v[31:0];
        end
        return $urandom();
    endfunction

    task automatic run_phase(input int items);
        int sent;
        int k;
        sent = 0;
        while (sent < items)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_word(CMD_INIT, pick_length());
                sent++;
                k = $urandom_range(0, n_set + 2);
                while (k > 0 && sent < items)
                begin
                    send_word(CMD_NEXT, $urandom());
                    sent++;
                    k--;
                end
            end
            else
            begin
                send_word($urandom_range(0, 1), $urandom());
                sent++;
            end
        end
    endtask

    initial
    begin
        rst_n <= 1'b0;
        cfg_valid <= 1'b0;
        cfg_index <= REG_RATIO;
        cfg_data <= 32'd0;
        in_valid <= 1'b0;
        command <= CMD_INIT;
        edge_length <= 32'd0;
        burst_left = 3;
        n_set = 1;
        fal_set = 0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset settings: next before init, init, step, past end
        send_word(CMD_NEXT, 32'hFFFF_FFFF);
        send_word(CMD_INIT, 32'd0);
        send_word(CMD_NEXT, 32'd0);
        send_word(CMD_NEXT, 32'd0);
        send_word(CMD_INIT, 32'hFFFF_FFFF);
        send_word(CMD_NEXT, 32'h5555_AAAA);

        set_config(32'h2000_0000, 11'd4, 1'b0, 32'd0);
        send_word(CMD_INIT, 32'd0);
        repeat (5)
            send_word(CMD_NEXT, 32'd0);

        set_config(32'h1000_0000, 11'd4, 1'b1, 32'h0001_0000);
        send_word(CMD_INIT, 32'd0);
        send_word(CMD_NEXT, 32'd0);
        send_word(CMD_INIT, 32'hFFFF_FFFF);
        send_word(CMD_INIT, 32'h000A_0000);
        repeat (5)
            send_word(CMD_NEXT, 32'd0);

        set_config(32'h1199_999A, 11'd8, 1'b1, 32'd0);
        run_phase(60);
        set_config(32'h1199_999A, 11'd8, 1'b0, 32'd0);
        run_phase(60);
        set_config(32'd0, 11'd5, 1'b1, 32'd0);
        run_phase(40);
        set_config(32'hFFFF_FFFF, 11'd16, 1'b1, 32'd0);
        run_phase(60);
        set_config(32'hFFFF_FFFF, 11'd3, 1'b0, 32'd0);
        run_phase(60);
        set_config(32'd1, 11'd4, 1'b0, 32'd0);
        run_phase(40);
        set_config(32'h0E66_6666, 11'd0, 1'b1, 32'd0);
        run_phase(60);
        set_config(32'h1004_1893, 11'd2047, 1'b0, 32'd0);
        run_phase(60);
        set_config(32'h1000_0000, 11'd6, 1'b1, 32'h0001_0000);
        run_phase(70);
        set_config(32'h1000_0000, 11'd12, 1'b0, 32'h0000_8000);
        run_phase(70);
        set_config(32'h1000_0000, 11'd3, 1'b1, 32'hFFFF_FFFF);
        run_phase(50);
        set_config(32'h1000_0000, 11'd1024, 1'b1, 32'h0001_0000);
        run_phase(30);

        repeat (6)
        begin
            set_config($urandom_range(32'h0800_0000, 32'h2000_0000),
                       $urandom_range(1, 40), $urandom_range(0, 1),
                       ($urandom_range(0, 1) == 0) ? 32'd0
                           : $urandom_range(32'h4000, 32'h40000));
            run_phase(70);
        end
        set_config($urandom(), $urandom_range(0, 2047), $urandom_range(0, 1), 32'd0);
        run_phase(70);

        wait_idle();
        repeat (100)
            @(posedge clk);
        if (fails == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

FILE: filelist.f
rtl/core/ggc_pkg.sv
rtl/core/ggc_ctrl.sv
rtl/core/ggc_dp.sv
rtl/core/geometric_grading_coefficients.sv
bench/ggc_checker.sv
bench/tb_top.sv
